### sv/pifrc_pkg.sv
// ----------------------------------------------------------------------------
// pifrc_pkg
// Shared types and constants for the fractional-N register calculator.
// ----------------------------------------------------------------------------
package pifrc_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OFFSET_KHZ  = 3'd0,
    REG_REF_HZ      = 3'd1,
    REG_R_DIVIDER   = 3'd2,
    REG_REF_DOUBLER = 3'd3,
    REG_REF_HALVE   = 3'd4,
    REG_MODULUS     = 3'd5,
    REG_POWER_LEVEL = 3'd6,
    REG_RF_ENABLE   = 3'd7
  } cfg_idx_t;

  localparam logic OP_INIT = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic [31:0] R5_WORD = 32'h0058_0005;
  localparam logic [31:0] R3_WORD = 32'h0000_0003;
  localparam logic [47:0] LOW_KHZ  = 48'd4400000;
  localparam logic [47:0] HIGH_KHZ = 48'd8800000;
  localparam logic [15:0] INT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic        op;
    logic [23:0] target_khz;
  } in_item_t;

  typedef struct packed {
    logic [31:0] reg_word;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [23:0] offset_khz;
    logic [27:0] ref_hz;
    logic [9:0]  r_divider;
    logic        ref_doubler;
    logic        ref_halve;
    logic [11:0] modulus;
    logic [1:0]  power_level;
    logic        rf_enable;
  } cfg_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic        op;
    logic [23:0] rf_khz;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_MUL,
    ST_DIV,
    ST_FRAC,
    ST_EMIT
  } back_state_t;

endpackage

### sv/pifrc_front.sv
// ----------------------------------------------------------------------------
// pifrc_front
// Accepts input items, applies the offset and passes commands to a queue.
// ----------------------------------------------------------------------------
module pifrc_front #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  pifrc_pkg::in_item_t in_item,
  input  logic [23:0]         offset_khz,
  input  logic                ref_zero,
  output logic                cmd_valid,
  input  logic                cmd_take,
  output pifrc_pkg::cmd_t     cmd
);
  import pifrc_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            mem [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            acc;
  logic            keep;
  cmd_t            cls;

  assign full = (count == (AW+1)'(Depth));
  assign acc  = push && !full;
  // A set item with no reference produces nothing and is dropped here.
  assign keep = acc && !(in_item.op == OP_SET && ref_zero);

  always_comb begin
    cls.op     = in_item.op;
    cls.rf_khz = (in_item.target_khz > offset_khz) ? in_item.target_khz - offset_khz : '0;
  end

  assign cmd_valid = (count != '0);
  assign cmd       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (keep) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (keep) begin
        wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_take && cmd_valid) begin
        rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(keep) - (AW+1)'(cmd_take && cmd_valid);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(Depth))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !(cmd_take && cmd_valid))
    else $error("take from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (keep && !(cmd_take && cmd_valid)) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

endmodule

### sv/pifrc_back.sv
// ----------------------------------------------------------------------------
// pifrc_back
// Computes divider select, INT and FRAC with a serial divider and emits words.
// ----------------------------------------------------------------------------
module pifrc_back #(
  parameter int unsigned MaxDivSel = 6,
  parameter int unsigned Repeats   = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pifrc_pkg::cfg_t      cfg,
  input  logic                 cmd_valid,
  output logic                 cmd_take,
  input  pifrc_pkg::cmd_t      cmd,
  output logic                 empty,
  input  logic                 pop,
  output pifrc_pkg::out_item_t out_item
);
  import pifrc_pkg::*;

  localparam int unsigned SelW = 3;
  localparam int unsigned CntW = 4;

  back_state_t state, state_next;
  logic        op;
  logic [47:0] val;        // rf << sel
  logic [SelW-1:0] sel;
  logic [2:0]  step;
  logic [47:0] num;
  logic [28:0] den;
  logic [47:0] quo;
  logic [29:0] rem;
  logic [5:0]  bitn;
  logic [41:0] fnum;      // 2*r*mod + den
  logic [29:0] fden;      // 2*den
  logic [12:0] fq;
  logic [CntW-1:0] idx;
  logic        pflag;
  logic        obuf_v;
  out_item_t   obuf;
  logic [31:0] r0_word;
  logic [15:0] int_v;
  logic [11:0] frac_v;
  logic [CntW-1:0] n_words;
  logic [29:0] rsh;
  logic [29:0] rem_next;
  logic        slot;

  assign empty    = !obuf_v;
  assign out_item = obuf;
  assign slot     = !obuf_v || pop;
  assign cmd_take = (state == ST_IDLE) && cmd_valid;
  assign n_words  = (op == OP_INIT) ? CntW'(5) : CntW'(2*Repeats);

  function automatic logic [31:0] r4(input logic [2:0] s, input cfg_t c);
    r4 = {9'd0, s, 14'd0, c.rf_enable, c.power_level, 3'b100};
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_valid) state_next = (cmd.op == OP_INIT) ? ST_EMIT : ST_SEL;
      ST_SEL:  if (step == 3'd7) state_next = ST_MUL;
      ST_MUL:  if (step == 3'd2) state_next = ST_DIV;
      ST_DIV:  if (bitn == 6'd0) state_next = ST_FRAC;
      ST_FRAC: if (bitn == 6'd0) state_next = ST_EMIT;
      ST_EMIT: if (slot && idx == n_words - 1'b1) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rsh = {rem[28:0], num[47]};
    rem_next = (rsh >= {1'b0, den}) ? rsh - {1'b0, den} : rsh;
    int_v  = 16'd0;
    frac_v = 12'd0;
    if (fq >= {1'b0, cfg.modulus}) begin
      if (quo + 48'd1 > 48'(INT_MAX)) int_v = INT_MAX;
      else int_v = quo[15:0] + 16'd1;
    end else if (quo > 48'(INT_MAX)) begin
      int_v = INT_MAX;
    end else begin
      int_v  = quo[15:0];
      frac_v = fq[11:0];
    end
    r0_word = {1'b0, int_v, frac_v, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      obuf_v <= 1'b0;
      pflag  <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && obuf_v && state != ST_EMIT) obuf_v <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          op   <= cmd.op;
          val  <= 48'(cmd.rf_khz);
          sel  <= '0;
          step <= '0;
          idx  <= '0;
        end
        ST_SEL: begin
          // Doublings first (up to MaxDivSel), then halvings: one per cycle.
          step <= step + 3'd1;
          if (val < LOW_KHZ && 32'(sel) < MaxDivSel) begin
            val <= val << 1;
            sel <= sel + 1'b1;
          end else if (val > HIGH_KHZ && sel != '0) begin
            val <= val >> 1;
            sel <= sel - 1'b1;
          end
        end
        ST_MUL: begin
          step <= step + 3'd1;
          if (step == 3'd0) num <= 48'(val[37:0] * 10'd500);
          else if (step == 3'd1) num <= 48'(num[47:0] * cfg.r_divider);
          else begin
            num  <= cfg.ref_halve ? num << 1 : num;
            den  <= cfg.ref_doubler ? {cfg.ref_hz, 1'b0} : {1'b0, cfg.ref_hz};
            rem  <= '0;
            quo  <= '0;
            bitn <= 6'd47;
          end
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          rem <= rem_next;
          quo <= {quo[46:0], (rsh >= {1'b0, den})};
          num <= num << 1;
          if (bitn == 6'd0) begin
            fnum <= 42'({rem_next[28:0], 1'b0} * cfg.modulus) + 42'(den);
            fden <= {den, 1'b0};
            fq   <= '0;
            bitn <= 6'd12;
          end else begin
            bitn <= bitn - 6'd1;
          end
        end
        ST_FRAC: begin
          // fq = floor(fnum / fden); the result never exceeds the modulus.
          if (42'(fden) << bitn <= fnum) begin
            fnum <= fnum - (42'(fden) << bitn);
            fq   <= fq | 13'(1 << bitn);
          end
          bitn <= bitn - 6'd1;
          if (bitn == 6'd0) begin
            pflag <= (quo >= 48'd75);
          end
        end
        ST_EMIT: begin
          if (slot) begin
            obuf_v <= 1'b1;
            idx    <= idx + 1'b1;
            obuf.last <= (idx == n_words - 1'b1);
            if (op == OP_INIT) begin
              case (idx)
                4'd0: obuf.reg_word <= R5_WORD;
                4'd1: obuf.reg_word <= r4(3'd0, cfg);
                4'd2: obuf.reg_word <= R3_WORD;
                4'd3: obuf.reg_word <= {6'd0, cfg.ref_doubler, cfg.ref_halve,
                                        cfg.r_divider, 14'b00111001000010};
                default: obuf.reg_word <= {4'd0, pflag, 12'd0, cfg.modulus, 3'b001};
              endcase
            end else begin
              obuf.reg_word <= idx[0] ? r0_word : r4(sel, cfg);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (obuf_v && !pop) |=> $stable(obuf))
    else $error("waiting result changed");
  assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> state == ST_IDLE)
    else $error("command taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FRAC) |-> rem < 30'(den))
    else $error("remainder not below divisor");

endmodule

### sv/pll_int_frac_register_calc.sv
// ----------------------------------------------------------------------------
// pll_int_frac_register_calc
// Fractional-N synthesizer register word calculator.
// ----------------------------------------------------------------------------
// Channel | Signals                         | Transaction when
// input   | push, full, in_item             | push && !full
// result  | empty, pop, out_item            | pop && !empty
// config  | cfg_valid, cfg_ready, cfg_index,| cfg_valid && cfg_ready
//         | cfg_data                        |
//
// A set-frequency item goes through taking the command, the divider select,
// the multiplies, the serial quotient and the fraction, then emits 2*REPEATS
// words at one per cycle while the result slot is free. An init item takes
// the command and emits five words, also one per cycle while the slot is free.
// A two-entry command queue lets the front accept while the back is busy.
// Reset is synchronous and clears the queue, the sequencer and the
// prescaler flag, and loads the register defaults. A stalled result holds.
module pll_int_frac_register_calc #(
  parameter int unsigned MAX_DIV_SEL = 6,
  parameter int unsigned REPEATS     = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  pifrc_pkg::in_item_t   in_item,
  output logic                  empty,
  input  logic                  pop,
  output pifrc_pkg::out_item_t  out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [27:0]           cfg_data
);
  import pifrc_pkg::*;

  cfg_t cfg;
  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_khz  <= '0;
      cfg.ref_hz      <= 28'd25000000;
      cfg.r_divider   <= 10'd1;
      cfg.ref_doubler <= 1'b0;
      cfg.ref_halve   <= 1'b0;
      cfg.modulus     <= 12'd4095;
      cfg.power_level <= 2'd3;
      cfg.rf_enable   <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_OFFSET_KHZ:  cfg.offset_khz  <= cfg_data[23:0];
        REG_REF_HZ:      cfg.ref_hz      <= cfg_data;
        REG_R_DIVIDER:   cfg.r_divider   <= cfg_data[9:0];
        REG_REF_DOUBLER: cfg.ref_doubler <= cfg_data[0];
        REG_REF_HALVE:   cfg.ref_halve   <= cfg_data[0];
        REG_MODULUS:     cfg.modulus     <= cfg_data[11:0];
        REG_POWER_LEVEL: cfg.power_level <= cfg_data[1:0];
        REG_RF_ENABLE:   cfg.rf_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pifrc_front #(.Depth(2)) u_front (
    .clk, .rst, .push, .full, .in_item,
    .offset_khz(cfg.offset_khz),
    .ref_zero(cfg.ref_hz == '0),
    .cmd_valid, .cmd_take, .cmd
  );

  pifrc_back #(.MaxDivSel(MAX_DIV_SEL), .Repeats(REPEATS)) u_back (
    .clk, .rst, .cfg, .cmd_valid, .cmd_take, .cmd, .empty, .pop, .out_item
  );

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the fractional-N register word calculator.
// Items are driven through the push/full queue interface and every result
// word popped from the block is compared with a locally computed prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pifrc_pkg::*;

  localparam int unsigned DIV_SEL_MAX = 6;
  localparam int unsigned WORD_REPEATS = 3;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic push;
  logic full;
  in_item_t in_item;
  logic empty;
  logic pop;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [27:0] cfg_data;

  pll_int_frac_register_calc #(
    .MAX_DIV_SEL(DIV_SEL_MAX),
    .REPEATS(WORD_REPEATS)
  ) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The predictor keeps its own copy of the register file and of the
  // prescaler flag, updated as transactions are accepted.
  cfg_t shadow_cfg;
  logic shadow_prescaler;
  out_item_t pending_words[$];
  int unsigned failures;
  int unsigned idle_cycles;
  bit stall_long;
  bit random_gaps;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Words that are common to the init sequence and the set sequence.
  function automatic logic [31:0] divider_power_word(input logic [2:0] sel);
    divider_power_word = {9'd0, sel, 14'd0, shadow_cfg.rf_enable,
                          shadow_cfg.power_level, 3'b100};
  endfunction

  // Builds the expected words for one accepted item and updates the
  // prescaler flag exactly as the block should.
  task automatic predict_words(input in_item_t item);
    logic [63:0] rf_khz;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quot;
    logic [63:0] rem_v;
    logic [63:0] frac;
    logic [63:0] mod_v;
    logic [31:0] r2;
    logic [31:0] int_word;
    logic [31:0] r4;
    int unsigned sel;
    sel = 0;
    if (item.op == OP_INIT) begin
      r2 = {8'd0, shadow_cfg.r_divider, 14'd0} | (32'd7 << 9) | (32'd1 << 6) | 32'd2;
      if (shadow_cfg.ref_doubler) r2 |= 32'd1 << 25;
      if (shadow_cfg.ref_halve) r2 |= 32'd1 << 24;
      pending_words.push_back('{R5_WORD, 1'b0});
      pending_words.push_back('{divider_power_word(3'd0), 1'b0});
      pending_words.push_back('{R3_WORD, 1'b0});
      pending_words.push_back('{r2, 1'b0});
      pending_words.push_back('{({4'd0, shadow_prescaler, 27'd0} |
                                 {17'd0, shadow_cfg.modulus, 3'b001}), 1'b1});
      return;
    end
    if (shadow_cfg.ref_hz == 0) return;
    rf_khz = (item.target_khz > shadow_cfg.offset_khz) ?
             64'(item.target_khz - shadow_cfg.offset_khz) : 64'd0;
    while ((rf_khz << sel) < 64'd4400000 && sel < DIV_SEL_MAX) sel++;
    while ((rf_khz << sel) > 64'd8800000 && sel > 0) sel--;
    num = (rf_khz << sel) * 64'd500 * 64'(shadow_cfg.r_divider) *
          (shadow_cfg.ref_halve ? 64'd2 : 64'd1);
    den = 64'(shadow_cfg.ref_hz) * (shadow_cfg.ref_doubler ? 64'd2 : 64'd1);
    quot = num / den;
    rem_v = num % den;
    shadow_prescaler = (num >= 64'd75 * den);
    mod_v = 64'(shadow_cfg.modulus);
    frac = (64'd2 * rem_v * mod_v + den) / (64'd2 * den);
    if (frac >= mod_v) begin
      frac = 0;
      quot += 1;
    end
    if (quot > 64'd65535) begin
      quot = 64'd65535;
      frac = 0;
    end
    r4 = divider_power_word(3'(sel));
    int_word = (32'(quot[15:0]) << 15) | (32'(frac[11:0]) << 3);
    for (int k = 0; k < WORD_REPEATS; k++) begin
      pending_words.push_back('{r4, 1'b0});
      pending_words.push_back('{int_word, (k == WORD_REPEATS - 1)});
    end
  endtask

  // Gaps are absent half of the time (always when random gaps are off), else mostly short, occasionally long.
  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (!random_gaps || roll < 50) gap_length = 0;
    else if (roll < 92) gap_length = $urandom_range(1, 3);
    else gap_length = $urandom_range(10, 60);
  endfunction

  // Sends one item; the prediction is formed at the accepting edge. Push
  // stays high after the transaction so that items can follow back to back;
  // it is dropped by the next gap or by drain.
  task automatic send_item(input logic op, input logic [23:0] target);
    int unsigned gap;
    gap = gap_length();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_item <= '{op, target};
    @(posedge clk);
    while (full) @(posedge clk);
    predict_words('{op, target});
    @(negedge clk);
  endtask

  // Waits until every expected word has been popped, then lets the block
  // finish any item that produces no words (zero reference) before config.
  task automatic drain();
    push <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [27:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_OFFSET_KHZ: shadow_cfg.offset_khz = value[23:0];
      REG_REF_HZ: shadow_cfg.ref_hz = value;
      REG_R_DIVIDER: shadow_cfg.r_divider = value[9:0];
      REG_REF_DOUBLER: shadow_cfg.ref_doubler = value[0];
      REG_REF_HALVE: shadow_cfg.ref_halve = value[0];
      REG_MODULUS: shadow_cfg.modulus = value[11:0];
      REG_POWER_LEVEL: shadow_cfg.power_level = value[1:0];
      REG_RF_ENABLE: shadow_cfg.rf_enable = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [23:0] offset, input logic [27:0] ref_freq,
                                input logic [9:0] rdiv, input logic dbl,
                                input logic hlv, input logic [11:0] modv,
                                input logic [1:0] pwr, input logic en);
    write_reg(REG_OFFSET_KHZ, 28'(offset));
    write_reg(REG_REF_HZ, ref_freq);
    write_reg(REG_R_DIVIDER, 28'(rdiv));
    write_reg(REG_REF_DOUBLER, 28'(dbl));
    write_reg(REG_REF_HALVE, 28'(hlv));
    write_reg(REG_MODULUS, 28'(modv));
    write_reg(REG_POWER_LEVEL, 28'(pwr));
    write_reg(REG_RF_ENABLE, 28'(en));
  endtask

  // Directed extremes under the reset defaults: init words, the target
  // range ends and the divider select limits.
  task automatic test_directed_defaults();
    send_item(OP_INIT, 24'd0);
    send_item(OP_SET, 24'd0);
    send_item(OP_SET, 24'hFFFFFF);
    send_item(OP_SET, 24'd2200000);
    send_item(OP_SET, 24'd4400001);
    send_item(OP_SET, 24'd1000);
    send_item(OP_SET, 24'd5000000);
    send_item(OP_INIT, 24'hFFFFFF);
    drain();
  endtask

  // Offset above target, a zero divider, the zero modulus carry, a
  // zero reference and INT saturation.
  task automatic test_special_cases();
    apply_settings(24'hFFFFFF, 28'd250000000, 10'd1023, 1'b1, 1'b1, 12'd4095,
                   2'd0, 1'b0);
    send_item(OP_SET, 24'd123456);
    send_item(OP_INIT, 24'd0);
    drain();
    apply_settings(24'd0, 28'd1, 10'd0, 1'b0, 1'b0, 12'd0, 2'd2, 1'b1);
    send_item(OP_SET, 24'd3000000);
    drain();
    write_reg(REG_R_DIVIDER, 28'd1023);
    send_item(OP_SET, 24'hFFFFFF);
    send_item(OP_SET, 24'd1);
    drain();
    write_reg(REG_MODULUS, 28'd2);
    write_reg(REG_REF_HZ, 28'd10000000);
    write_reg(REG_R_DIVIDER, 28'd3);
    send_item(OP_SET, 24'd2500017);
    send_item(OP_SET, 24'd3333333);
    drain();
    write_reg(REG_REF_HZ, 28'd0);
    send_item(OP_SET, 24'd2500000);
    send_item(OP_INIT, 24'd0);
    drain();
  endtask

  // Random items over several register settings; extremes come first.
  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      random_gaps = (phase != 3);
      if (phase == 0)
        apply_settings(24'd0, 28'd25000000, 10'd1, 1'b0, 1'b0, 12'd4095, 2'd3, 1'b1);
      else if (phase == 1)
        apply_settings(24'hFFFFFF, 28'd250000000, 10'd1023, 1'b1, 1'b1, 12'd4095,
                       2'd0, 1'b0);
      else
        apply_settings(24'($urandom_range(0, 200000)),
                       ($urandom_range(9) == 0) ? 28'($urandom_range(1, 250000000)) :
                         28'($urandom_range(10000000, 250000000)),
                       10'($urandom_range(1, 1023)), 1'($urandom), 1'($urandom),
                       12'($urandom_range(2, 4095)), 2'($urandom), 1'($urandom));
      for (int k = 0; k < 56; k++) begin
        logic [23:0] target;
        if ($urandom_range(9) == 0) target = 24'($urandom);
        else target = 24'($urandom_range(30000, 8000000));
        send_item(($urandom_range(7) == 0) ? OP_INIT : OP_SET, target);
      end
      drain();
    end
  endtask

  // The receiver stops popping for a long stretch while items keep coming,
  // so the block fills and holds full high.
  task automatic test_backpressure();
    random_gaps = 1'b0;
    stall_long = 1'b1;
    for (int k = 0; k < 10; k++) send_item(OP_SET, 24'($urandom_range(30000, 8000000)));
    drain();
  endtask

  // Result side: random pop gaps, with a long hold-off on request.
  initial begin
    int unsigned gap;
    pop = 1'b0;
    stall_long = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_long) begin
        pop <= 1'b0;
        repeat (600) @(negedge clk);
        stall_long = 1'b0;
      end
      gap = gap_length();
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
    end
  end

  // Checks each popped word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_words.size() == 0) begin
        $error("result word %h with nothing expected", out_item.reg_word);
        failures++;
      end else begin
        out_item_t want;
        want = pending_words.pop_front();
        if (out_item.reg_word !== want.reg_word) begin
          $error("reg_word: expected %h, actual %h", want.reg_word, out_item.reg_word);
          failures++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_item.last);
          failures++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pll_int_frac_register_calc regression: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failures = 0;
    idle_cycles = 0;
    random_gaps = 1'b1;
    shadow_cfg = '{offset_khz: 24'd0, ref_hz: 28'd25000000, r_divider: 10'd1,
                   ref_doubler: 1'b0, ref_halve: 1'b0, modulus: 12'd4095,
                   power_level: 2'd3, rf_enable: 1'b1};
    shadow_prescaler = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_defaults();
    test_special_cases();
    test_backpressure();
    test_random_settings();
    drain();
    if (failures == 0) $display("pll_int_frac_register_calc regression: pass");
    else $display("pll_int_frac_register_calc regression: fail");
    $finish;
  end

endmodule
